### rtl/pvenc_pkg.sv
// Package for the prefix varint value encoder: type codes, frame type and the encode function.
package pvenc_pkg;

    localparam logic [3:0] OP_BOOL    = 4'd0;
    localparam logic [3:0] OP_INT8    = 4'd1;
    localparam logic [3:0] OP_UINT8   = 4'd2;
    localparam logic [3:0] OP_UINT16  = 4'd3;
    localparam logic [3:0] OP_INT16   = 4'd4;
    localparam logic [3:0] OP_UINT32  = 4'd5;
    localparam logic [3:0] OP_INT32   = 4'd6;
    localparam logic [3:0] OP_FLOAT32 = 4'd7;
    localparam logic [3:0] OP_UINT64  = 4'd8;
    localparam logic [3:0] OP_INT64   = 4'd9;
    localparam logic [3:0] OP_FLOAT64 = 4'd10;

    localparam int          MaxBytes   = 9;
    localparam logic [63:0] SpaceStart = 64'h7f;

    // One encoded value: bytes in stream order (entry 0 goes out first) and a byte count.
    typedef struct packed {
        logic [3:0]               count;
        logic [MaxBytes-1:0][7:0] bytes;
    } frame_t;

    // Zigzag at 16, 32 or 64 bits: shift left by one, invert when the sign bit is set.
    function automatic logic [63:0] zigzag16(input logic [63:0] x);
        logic [15:0] uv;
        uv = {x[14:0], 1'b0};
        return {48'h0, x[15] ? ~uv : uv};
    endfunction

    function automatic logic [63:0] zigzag32(input logic [63:0] x);
        logic [31:0] uv;
        uv = {x[30:0], 1'b0};
        return {32'h0, x[31] ? ~uv : uv};
    endfunction

    function automatic logic [63:0] zigzag64(input logic [63:0] x);
        logic [63:0] uv;
        uv = {x[62:0], 1'b0};
        return x[63] ? ~uv : uv;
    endfunction

    // Prefix varint of m: k extra bytes after a prefix byte carrying k leading ones.
    function automatic frame_t varint(input logic [63:0] m);
        frame_t      f;
        logic [3:0]  k;
        logic [71:0] ext;
        logic [71:0] hi;
        logic [71:0] lo;
        logic [7:0]  tag;
        ext = {8'h00, m};
        k   = 4'd8;
        for (int kk = 7; kk >= 0; kk--) begin
            if ((m >> (8 * kk)) <= (SpaceStart >> kk)) begin
                k = 4'(kk);
            end
        end
        hi  = ext >> (7'(k) * 7'd8);
        lo  = ext << ((7'd8 - 7'(k)) * 7'd8);
        tag = ~(8'hff >> k);
        f.count    = k + 4'd1;
        f.bytes[0] = hi[7:0] | tag;
        for (int i = 1; i < MaxBytes; i++) begin
            f.bytes[i] = lo[63 - 8 * (i - 1) -: 8];
        end
        return f;
    endfunction

    function automatic frame_t encode(input logic [3:0] op, input logic [63:0] v);
        frame_t f;
        f       = '0;
        case (op)
            OP_BOOL: begin
                f.count    = 4'd1;
                f.bytes[0] = {7'h00, |v[7:0]};
            end
            OP_INT8, OP_UINT8: begin
                f.count    = 4'd1;
                f.bytes[0] = v[7:0];
            end
            OP_UINT16:  f = varint({48'h0, v[15:0]});
            OP_INT16:   f = varint(zigzag16(v));
            OP_UINT32:  f = varint({32'h0, v[31:0]});
            OP_INT32:   f = varint(zigzag32(v));
            OP_FLOAT32: f = varint({32'h0, v[7:0], v[15:8], v[23:16], v[31:24]});
            OP_UINT64:  f = varint(v);
            OP_INT64:   f = varint(zigzag64(v));
            OP_FLOAT64: f = varint({v[7:0], v[15:8], v[23:16], v[31:24],
                                    v[39:32], v[47:40], v[55:48], v[63:56]});
            default:    f = '0;
        endcase
        return f;
    endfunction

endpackage

### rtl/prefix_varint_value_encoder.sv
// Top level of the prefix varint value encoder: input register, encoder and byte serializer.
//
//  Channel   Handshake              Payload                 Beat
//  --------  ---------------------  ----------------------  ---------------------------
//  command   start, busy            operation, value        one typed value
//  result    out_strobe (no stall)  out_byte, last_byte     one serialized byte
//
// A command beat is taken on a clock edge where start is high and busy is low. It waits in the
// input register until the serializer is empty or sending its last byte, and its first byte is
// on the result ports in the cycle after the edge that loads its frame. A value goes out one byte
// per cycle (1 to 9 bytes) and the next frame loads on the cycle of the last byte with no gap; an
// unused type code produces no bytes. busy is high while a beat waits on a frame still being
// sent. Reset (rst_n low) clears the valid flag and the byte count.
module prefix_varint_value_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  operation,
    input  logic [63:0] value,
    output logic        out_strobe,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    // Input register.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [3:0]  in_op_reg;
    logic [63:0] in_value_reg;

    // Serializer: frame bytes in stream order and the number still to send.
    logic [3:0]                           cnt_reg;
    logic [3:0]                           cnt_next;
    logic [pvenc_pkg::MaxBytes-1:0][7:0]  frame_reg;
    logic [pvenc_pkg::MaxBytes-1:0][7:0]  frame_next;

    pvenc_pkg::frame_t enc;
    logic              frame_free;
    logic              move;
    logic              accept;

    assign enc = pvenc_pkg::encode(in_op_reg, in_value_reg);

    // The serializer can take a new frame when it is empty or sending its last byte.
    assign frame_free = (cnt_reg <= 4'd1);
    assign move       = in_valid_reg && frame_free;
    assign busy       = in_valid_reg && !frame_free;
    assign accept     = start && !busy;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        frame_next = {8'h00, frame_reg[pvenc_pkg::MaxBytes-1:1]};
        if (move)
        begin
            cnt_next   = enc.count;
            frame_next = enc.bytes;
        end
        else if (cnt_reg != 4'd0)
        begin
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 4'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg    <= operation;
            in_value_reg <= value;
        end
        frame_reg <= frame_next;
    end

    assign out_strobe = (cnt_reg != 4'd0);
    assign out_byte   = frame_reg[0];
    assign last_byte  = (cnt_reg == 4'd1);

endmodule

### sim/tb.sv
// Testbench for prefix_varint_value_encoder: directed and random typed values, byte-level checking.
module tb;

    // One expected byte of the serialized stream.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    // Holds the byte stream the encoder should produce and compares it with what comes out.
    // Every accepted value is encoded here at once; bytes are then matched in order.
    class varint_checker;
        stream_byte_t pending_bytes[$];
        int           failures;
        int           values_seen;
        int           unencoded_values;
        int           nine_byte_values;
        int           bytes_checked;

        function void push_byte(logic [7:0] data, logic last);
            stream_byte_t sb;
            sb.data = data;
            sb.last = last;
            pending_bytes.push_back(sb);
        endfunction

        // Zigzag at a given width: shift left by one, invert all bits if the sign bit was set.
        function logic [63:0] zigzag_at(logic [63:0] v, int width);
            logic [63:0] mask;
            logic [63:0] shifted;
            mask    = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
            shifted = (v << 1) & mask;
            return v[width-1] ? (~shifted & mask) : shifted;
        endfunction

        // Reverses the order of the low n bytes.
        function logic [63:0] swap_bytes(logic [63:0] v, int n);
            logic [63:0] r;
            r = '0;
            for (int i = 0; i < n; i++)
            begin
                r = {r[55:0], v[8*i +: 8]};
            end
            return r;
        endfunction

        // Prefix varint: bytes are built from the tail; each extra byte halves the room
        // left in the prefix byte and adds one more leading one to its tag.
        function void push_varint(logic [63:0] m);
            logic [7:0]  tail [9];
            logic [63:0] room;
            logic [7:0]  tag;
            int          pos;
            room = 64'h7f;
            tag  = 8'h00;
            pos  = 8;
            forever
            begin
                if (m <= room || pos == 0)
                begin
                    tail[pos] = m[7:0] | tag;
                    break;
                end
                tail[pos] = m[7:0];
                m    = m >> 8;
                room = room >> 1;
                tag  = {1'b1, tag[7:1]};
                pos--;
            end
            if (pos == 0)
                nine_byte_values++;
            for (int k = pos; k <= 8; k++)
                push_byte(tail[k], k == 8);
        endfunction

        // Notes one accepted value and appends the bytes it must produce.
        function void note_value(logic [3:0] op, logic [63:0] v);
            values_seen++;
            case (op)
                pvenc_pkg::OP_BOOL:    push_byte({7'd0, |v[7:0]}, 1'b1);
                pvenc_pkg::OP_INT8,
                pvenc_pkg::OP_UINT8:   push_byte(v[7:0], 1'b1);
                pvenc_pkg::OP_UINT16:  push_varint({48'd0, v[15:0]});
                pvenc_pkg::OP_INT16:   push_varint(zigzag_at(v, 16));
                pvenc_pkg::OP_UINT32:  push_varint({32'd0, v[31:0]});
                pvenc_pkg::OP_INT32:   push_varint(zigzag_at(v, 32));
                pvenc_pkg::OP_FLOAT32: push_varint(swap_bytes(v, 4));
                pvenc_pkg::OP_UINT64:  push_varint(v);
                pvenc_pkg::OP_INT64:   push_varint(zigzag_at(v, 64));
                pvenc_pkg::OP_FLOAT64: push_varint(swap_bytes(v, 8));
                default:               unencoded_values++;
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            stream_byte_t want;
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected byte %02h last %0b", data, last);
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data || last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: byte %0d expected %02h last %0b, got %02h last %0b",
                             bytes_checked, want.data, want.last, data, last);
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  operation = '0;
    logic [63:0] value = '0;
    logic        out_strobe;
    logic [7:0]  out_byte;
    logic        last_byte;

    varint_checker chk = new();

    // Chance, in percent, that the sender leaves a cycle empty before the next beat.
    int sender_idle_pct = 0;
    int quiet_cycles = 0;

    localparam int WatchdogLimit = 4000;

    prefix_varint_value_encoder DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .value      (value),
        .out_strobe (out_strobe),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Every strobed byte is compared with the oldest expected one. The receiver has no
    // way to push back, so there is nothing to drive on this side.
    always @(posedge clk)
    begin
        if (rst_n && out_strobe)
            chk.check_byte(out_byte, last_byte);
    end

    // The watchdog restarts whenever a command beat is taken or a byte comes out. A run
    // that goes quiet for this long has hung somewhere.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("ERROR: no activity for %0d cycles, %0d bytes still expected",
                     WatchdogLimit, chk.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sends one command beat. Inputs change only on the falling edge; the beat is taken
    // on the first rising edge where busy is low. When the sender does not idle, start
    // simply stays high into the next beat with new fields.
    task automatic send_value(input logic [3:0] op, input logic [63:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start     = 1'b0;
            operation = 4'($urandom);
            value     = {$urandom, $urandom};
        end
        @(negedge clk);
        start     = 1'b1;
        operation = op;
        value     = v;
        do
            @(posedge clk);
        while (busy);
        chk.note_value(op, v);
    endtask

    // Drops start and holds off until every expected byte has come out.
    task automatic drain_stream();
        @(negedge clk);
        start = 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    // Values of every magnitude, so every varint length from one to nine bytes shows up,
    // along with small negatives for the zigzag path and edges around powers of two.
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          nbits;
        w = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1:
            begin
                nbits = $urandom_range(64);
                if (nbits < 64)
                    w = w & ((64'd1 << nbits) - 64'd1);
            end
            2: w = ~{56'd0, 8'($urandom)};
            default: w = (64'd1 << $urandom_range(63)) + 64'($urandom_range(2)) - 64'd1;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] random_op();
        if ($urandom_range(99) < 6)
            return 4'($urandom_range(11, 15));
        return 4'($urandom_range(pvenc_pkg::OP_BOOL, pvenc_pkg::OP_FLOAT64));
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed values: field extremes, every type, and the cases that need care:
        // bool with only high bits set, unused type codes, and the all-ones uint64.
        sender_idle_pct = 0;
        send_value(pvenc_pkg::OP_BOOL,    64'h0);
        send_value(pvenc_pkg::OP_BOOL,    64'hffff_ffff_ffff_ff00);
        send_value(pvenc_pkg::OP_BOOL,    64'h80);
        send_value(pvenc_pkg::OP_INT8,    64'hff);
        send_value(pvenc_pkg::OP_UINT8,   64'hffff_ffff_ffff_ff7f);
        send_value(pvenc_pkg::OP_UINT16,  64'h7f);
        send_value(pvenc_pkg::OP_UINT16,  64'h80);
        send_value(pvenc_pkg::OP_UINT16,  64'hffff);
        send_value(pvenc_pkg::OP_INT16,   64'hffff);
        send_value(pvenc_pkg::OP_INT16,   64'h8000);
        send_value(pvenc_pkg::OP_UINT32,  64'hffff_ffff);
        send_value(pvenc_pkg::OP_INT32,   64'h8000_0000);
        send_value(pvenc_pkg::OP_INT32,   64'h7fff_ffff);
        send_value(pvenc_pkg::OP_FLOAT32, 64'h3f80_0000);
        send_value(4'd11,                 64'hffff_ffff_ffff_ffff);
        send_value(pvenc_pkg::OP_UINT64,  64'hffff_ffff_ffff_ffff);
        send_value(pvenc_pkg::OP_UINT64,  64'h0);
        send_value(pvenc_pkg::OP_UINT64,  64'h00ff_ffff_ffff_ffff);
        send_value(pvenc_pkg::OP_INT64,   64'h8000_0000_0000_0000);
        send_value(pvenc_pkg::OP_INT64,   64'h7fff_ffff_ffff_ffff);
        send_value(pvenc_pkg::OP_FLOAT64, 64'h3ff0_0000_0000_0000);
        send_value(4'd15,                 64'h0);
        send_value(pvenc_pkg::OP_UINT8,   64'h0);
        drain_stream();

        // Random values in three phases: a busy sender, a sparse one, then back to back.
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 71 : 0;
            for (int i = 0; i < 112; i++)
                send_value(random_op(), random_word());
            drain_stream();
        end

        repeat (20) @(posedge clk);

        if (chk.pending() != 0)
            $display("ERROR: %0d expected bytes never came out", chk.pending());
        $display("Encoded %0d values of all eleven types plus %0d with unused codes;",
                 chk.values_seen - chk.unencoded_values, chk.unencoded_values);
        $display("compared %0d bytes, %0d values took the full nine bytes, %0d mismatches.",
                 chk.bytes_checked, chk.nine_byte_values, chk.failures);
        if (chk.failures == 0 && chk.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
